### rtl/core/blca_pkg.sv
// ----------------------------------------------------------------------------
// blca_pkg
// Shared sizes, operation codes and helpers of the binary lifting lowest
// common ancestor unit.
// ----------------------------------------------------------------------------
`default_nettype none

package blca_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int JUMP_LEVELS = 11;

  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = 10;
  localparam int STEPS_W   = 10;
  localparam int LEVEL_W   = $clog2(JUMP_LEVELS);
  localparam int LVL_CNT_W = $clog2(JUMP_LEVELS + 1);

  localparam int TABLE_DEPTH = NODE_COUNT * JUMP_LEVELS;
  localparam int TABLE_AW    = LEVEL_W + NODE_W;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_KTH   = 2'd2;
  localparam logic [1:0] OP_LCA   = 2'd3;

  // any set bit at or above the table reach
  function automatic logic beyond_reach(input logic [STEPS_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return (wide >> JUMP_LEVELS) != 32'd0;
  endfunction

endpackage

`default_nettype wire

### rtl/core/binary_lifting_lca_unit.sv
// ----------------------------------------------------------------------------
// binary_lifting_lca_unit
// Power-of-two ancestor table with k-th ancestor and lowest common ancestor
// queries, held in a jump table memory and a depth memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A load gives no
// result. A build first clears the sentinel row at every level, then reads,
// reads again and writes each further table entry, and ends with one result
// with build_done set. Queries read the jump table memory through its single
// read port, one read per ancestor step. Before a build, or when the steps of
// a k-th ancestor query lie beyond the table reach, a query answers 0 in the
// cycle after it is taken. Each result is shown for one cycle under strobe
// and must be taken then; a new command may be started in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_lifting_lca_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     operation,
  input  wire logic [blca_pkg::NODE_W-1:0]    node_a,
  input  wire logic [blca_pkg::NODE_W-1:0]    node_b,
  input  wire logic [blca_pkg::NODE_W-1:0]    parent_in,
  input  wire logic [blca_pkg::DEPTH_W-1:0]   depth_in,
  input  wire logic [blca_pkg::STEPS_W-1:0]   steps,
  output logic                                strobe,
  output logic      [blca_pkg::NODE_W-1:0]    answer_node,
  output logic                                build_done
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_BRD1  = 4'd2;
  localparam logic [3:0] S_BRD2  = 4'd3;
  localparam logic [3:0] S_BWR   = 4'd4;
  localparam logic [3:0] S_DEPA  = 4'd5;
  localparam logic [3:0] S_DEPB  = 4'd6;
  localparam logic [3:0] S_SWAP  = 4'd7;
  localparam logic [3:0] S_LIFT  = 4'd8;
  localparam logic [3:0] S_LWAIT = 4'd9;
  localparam logic [3:0] S_DRA   = 4'd10;
  localparam logic [3:0] S_DRB   = 4'd11;
  localparam logic [3:0] S_DCMP  = 4'd12;
  localparam logic [3:0] S_FRD   = 4'd13;
  localparam logic [3:0] S_FWAIT = 4'd14;
  localparam logic [3:0] S_SPARE = 4'd15;

  localparam int NW  = blca_pkg::NODE_W;
  localparam int DW  = blca_pkg::DEPTH_W;
  localparam int LW  = blca_pkg::LEVEL_W;
  localparam int LCW = blca_pkg::LVL_CNT_W;
  localparam int KB  = blca_pkg::JUMP_LEVELS;

  localparam logic [LCW-1:0] LVL_TOP  = LCW'(blca_pkg::JUMP_LEVELS - 1);
  localparam logic [LCW-1:0] LVL_END  = LCW'(blca_pkg::JUMP_LEVELS);
  localparam logic [NW-1:0]  NODE_END = NW'(blca_pkg::NODE_COUNT - 1);

  logic [3:0]     state;
  logic           table_built;
  logic           is_ca;
  logic [LCW-1:0] lvl;
  logic [NW-1:0]  a;
  logic [NW-1:0]  b;
  logic [NW-1:0]  ua;
  logic [DW-1:0]  da;
  logic [KB-1:0]  k;

  logic                         accept;
  logic [LW-1:0]                lvl_l;
  logic [LCW-1:0]               lvl_prev;
  logic [LW-1:0]                lvl_prev_l;
  logic                         swap;
  logic [DW-1:0]                depth_gap;

  logic                         jt_we;
  logic [blca_pkg::TABLE_AW-1:0] jt_waddr;
  logic [NW-1:0]                jt_wdata;
  logic [blca_pkg::TABLE_AW-1:0] jt_raddr;
  logic [NW-1:0]                jt_rdata;

  logic                         dp_we;
  logic [NW-1:0]                dp_raddr;
  logic [DW-1:0]                dp_rdata;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign lvl_l      = lvl[LW-1:0];
  assign lvl_prev   = lvl - LCW'(1);
  assign lvl_prev_l = lvl_prev[LW-1:0];
  assign swap       = (dp_rdata > da);
  assign depth_gap  = swap ? (dp_rdata - da) : (da - dp_rdata);

  always_comb begin
    jt_we    = 1'b0;
    jt_waddr = {LW'(0), node_a};
    jt_wdata = parent_in;
    jt_raddr = {lvl_l, a};
    dp_we    = 1'b0;
    dp_raddr = a;
    if (accept && operation == blca_pkg::OP_LOAD) begin
      jt_we = 1'b1;
      dp_we = 1'b1;
    end
    unique case (state)
      S_CLR: begin
        jt_we    = 1'b1;
        jt_waddr = {lvl_l, NW'(0)};
        jt_wdata = '0;
      end
      S_BRD1: jt_raddr = {lvl_prev_l, a};
      S_BRD2: jt_raddr = {lvl_prev_l, jt_rdata};
      S_BWR: begin
        jt_we    = 1'b1;
        jt_waddr = {lvl_l, a};
        jt_wdata = jt_rdata;
      end
      S_DRB:   jt_raddr = {lvl_l, b};
      S_FRD:   jt_raddr = {LW'(0), a};
      S_DEPB:  dp_raddr = b;
      default: begin
      end
    endcase
  end

  blca_ram #(
    .WIDTH (NW),
    .DEPTH (blca_pkg::TABLE_DEPTH)
  ) u_jump_ram (
    .clk   (clk),
    .we    (jt_we),
    .waddr (jt_waddr),
    .wdata (jt_wdata),
    .raddr (jt_raddr),
    .rdata (jt_rdata)
  );

  blca_ram #(
    .WIDTH (DW),
    .DEPTH (blca_pkg::NODE_COUNT)
  ) u_depth_ram (
    .clk   (clk),
    .we    (dp_we),
    .waddr (node_a),
    .wdata (depth_in),
    .raddr (dp_raddr),
    .rdata (dp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strobe      <= 1'b0;
      table_built <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (operation)
              blca_pkg::OP_LOAD: table_built <= 1'b0;
              blca_pkg::OP_BUILD: begin
                lvl   <= '0;
                state <= S_CLR;
              end
              blca_pkg::OP_KTH: begin
                if (!table_built || blca_pkg::beyond_reach(steps)) begin
                  strobe      <= 1'b1;
                  answer_node <= '0;
                  build_done  <= 1'b0;
                end else begin
                  a     <= node_a;
                  k     <= KB'(steps);
                  lvl   <= '0;
                  is_ca <= 1'b0;
                  state <= S_LIFT;
                end
              end
              blca_pkg::OP_LCA: begin
                if (!table_built) begin
                  strobe      <= 1'b1;
                  answer_node <= '0;
                  build_done  <= 1'b0;
                end else begin
                  a     <= node_a;
                  b     <= node_b;
                  is_ca <= 1'b1;
                  state <= S_DEPA;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          if (lvl == LVL_TOP) begin
            lvl   <= LCW'(1);
            a     <= NW'(1);
            state <= S_BRD1;
          end else begin
            lvl <= lvl + LCW'(1);
          end
        end
        S_BRD1: state <= S_BRD2;
        S_BRD2: state <= S_BWR;
        S_BWR: begin
          if (a == NODE_END) begin
            if (lvl == LVL_TOP) begin
              table_built <= 1'b1;
              strobe      <= 1'b1;
              answer_node <= '0;
              build_done  <= 1'b1;
              state       <= S_IDLE;
            end else begin
              lvl   <= lvl + LCW'(1);
              a     <= NW'(1);
              state <= S_BRD1;
            end
          end else begin
            a     <= a + NW'(1);
            state <= S_BRD1;
          end
        end
        S_DEPA: state <= S_DEPB;
        S_DEPB: begin
          da    <= dp_rdata;
          state <= S_SWAP;
        end
        S_SWAP: begin
          if (swap) begin
            a <= b;
            b <= a;
          end
          if (blca_pkg::beyond_reach(blca_pkg::STEPS_W'(depth_gap))) begin
            strobe      <= 1'b1;
            answer_node <= '0;
            build_done  <= 1'b0;
            state       <= S_IDLE;
          end else begin
            k     <= KB'(depth_gap);
            lvl   <= '0;
            state <= S_LIFT;
          end
        end
        S_LIFT: begin
          if (lvl == LVL_END) begin
            if (!is_ca || a == b) begin
              strobe      <= 1'b1;
              answer_node <= a;
              build_done  <= 1'b0;
              state       <= S_IDLE;
            end else begin
              lvl   <= LVL_TOP;
              state <= S_DRA;
            end
          end else if (k[lvl_l]) begin
            state <= S_LWAIT;
          end else begin
            lvl <= lvl + LCW'(1);
          end
        end
        S_LWAIT: begin
          a     <= jt_rdata;
          lvl   <= lvl + LCW'(1);
          state <= S_LIFT;
        end
        S_DRA: state <= S_DRB;
        S_DRB: begin
          ua    <= jt_rdata;
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (ua != jt_rdata) begin
            a <= ua;
            b <= jt_rdata;
          end
          if (lvl == '0) begin
            state <= S_FRD;
          end else begin
            lvl   <= lvl_prev;
            state <= S_DRA;
          end
        end
        S_FRD: state <= S_FWAIT;
        S_FWAIT: begin
          strobe      <= 1'b1;
          answer_node <= jt_rdata;
          build_done  <= 1'b0;
          state       <= S_IDLE;
        end
        S_SPARE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result comes only from a running command or a query taken the cycle before
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(busy) || $past(start && operation != blca_pkg::OP_LOAD)))
    else $error("result without a command in flight");

  // a build result leaves the table marked as built
  a_build_marks: assert property (@(posedge clk) disable iff (rst)
    (strobe && build_done) |-> table_built)
    else $error("build result while table not marked built");

  // the build fill never writes level 0
  a_build_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_BWR) |-> (lvl != '0 && lvl < LVL_END))
    else $error("build write at bad level");

  // a lift step reads inside the table
  a_lift_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_LWAIT) |-> (lvl < LVL_END))
    else $error("lift read beyond table levels");

endmodule

`default_nettype wire

### rtl/core/blca_ram.sv
// ----------------------------------------------------------------------------
// blca_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### tb/tb_binary_lifting_lca_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_lifting_lca_unit
// Loads a whole tree and single node edits, builds the ancestor table and
// checks every k-th ancestor and common ancestor answer against a predictor
// that keeps its own copy of the parent, depth and jump tables.
// ----------------------------------------------------------------------------
module tb_binary_lifting_lca_unit;

  localparam int NODE_W      = blca_pkg::NODE_W;
  localparam int DEPTH_W     = blca_pkg::DEPTH_W;
  localparam int STEPS_W     = blca_pkg::STEPS_W;
  localparam int NODE_COUNT  = blca_pkg::NODE_COUNT;
  localparam int JUMP_LEVELS = blca_pkg::JUMP_LEVELS;

  localparam int CYCLE_LIMIT       = 4_000_000;
  localparam int DRAIN_CYCLES      = 80;
  localparam int QUERIES_PER_PHASE = 16;
  localparam int PHASES            = 6;
  localparam int EDIT_BURST        = 24;
  localparam int FIELD_MAX         = (1 << NODE_W) - 1;
  localparam int IDLE_PCT          = 38;
  localparam int STEADY_FROM       = 1060;
  localparam int STEADY_TO         = 1180;
  localparam int REPORT_CAP        = 40;

  typedef enum int {SHAPE_CHAIN, SHAPE_BUSHY, SHAPE_MIXED} tree_shape_t;

  typedef struct {
    logic [1:0]         op;
    logic [NODE_W-1:0]  na;
    logic [NODE_W-1:0]  nb;
    logic [NODE_W-1:0]  par;
    logic [DEPTH_W-1:0] dep;
    logic [STEPS_W-1:0] k;
  } node_cmd_t;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic              done;
  } lca_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = blca_pkg::OP_LOAD;
  logic [NODE_W-1:0] node_a = '0;
  logic [NODE_W-1:0] node_b = '0;
  logic [NODE_W-1:0] parent_in = '0;
  logic [DEPTH_W-1:0] depth_in = '0;
  logic [STEPS_W-1:0] steps = '0;
  logic busy;
  logic strobe;
  logic [NODE_W-1:0] answer_node;
  logic build_done;

  binary_lifting_lca_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .node_a      (node_a),
    .node_b      (node_b),
    .parent_in   (parent_in),
    .depth_in    (depth_in),
    .steps       (steps),
    .strobe      (strobe),
    .answer_node (answer_node),
    .build_done  (build_done)
  );

  node_cmd_t   command_q[$];
  lca_answer_t answer_q[$];
  node_cmd_t   shown_cmd;

  logic [NODE_W-1:0]  anc_tab [NODE_COUNT][JUMP_LEVELS];
  logic [DEPTH_W-1:0] depth_mem [NODE_COUNT];
  logic               table_ready = 1'b0;

  int gen_par [NODE_COUNT];
  int gen_dep [NODE_COUNT];

  int n_sent = 0;
  int n_loads = 0;
  int n_builds = 0;
  int n_kth = 0;
  int n_lca = 0;
  int n_checked = 0;
  int n_errors = 0;
  int cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // node numbers past the table act as the sentinel
  function automatic int fold(input int v);
    return (v < NODE_COUNT) ? v : 0;
  endfunction

  function automatic int climb(input int node, input int k);
    int cur;
    cur = fold(node);
    if ((k >> JUMP_LEVELS) != 0) return 0;
    for (int i = 0; i < JUMP_LEVELS; i++) begin
      if (((k >> i) & 1) != 0) cur = fold(anc_tab[cur][i]);
    end
    return cur;
  endfunction

  function automatic int common_root(input int na, input int nb);
    int a, b, t, ua, ub;
    a = fold(na);
    b = fold(nb);
    if (depth_mem[b] > depth_mem[a]) begin
      t = a;
      a = b;
      b = t;
    end
    a = climb(a, int'(depth_mem[a]) - int'(depth_mem[b]));
    if (a == b) return a;
    for (int i = JUMP_LEVELS - 1; i >= 0; i--) begin
      ua = fold(anc_tab[a][i]);
      ub = fold(anc_tab[b][i]);
      if (ua != ub) begin
        a = ua;
        b = ub;
      end
    end
    return fold(anc_tab[a][0]);
  endfunction

  function automatic void rebuild_table();
    for (int j = 0; j < JUMP_LEVELS; j++) anc_tab[0][j] = '0;
    for (int j = 1; j < JUMP_LEVELS; j++) begin
      for (int i = 1; i < NODE_COUNT; i++) begin
        anc_tab[i][j] = anc_tab[fold(anc_tab[i][j-1])][j-1];
      end
    end
    table_ready = 1'b1;
  endfunction

  function automatic void predict_command(input node_cmd_t c);
    lca_answer_t r;
    r.node = '0;
    r.done = 1'b0;
    case (c.op)
      blca_pkg::OP_LOAD: begin
        if (int'(c.na) < NODE_COUNT) begin
          anc_tab[c.na][0] = c.par;
          depth_mem[c.na] = c.dep;
        end
        table_ready = 1'b0;
        n_loads++;
      end
      blca_pkg::OP_BUILD: begin
        rebuild_table();
        r.done = 1'b1;
        n_builds++;
        answer_q.push_back(r);
      end
      blca_pkg::OP_KTH: begin
        if (table_ready) r.node = NODE_W'(climb(c.na, c.k));
        n_kth++;
        answer_q.push_back(r);
      end
      blca_pkg::OP_LCA: begin
        if (table_ready) r.node = NODE_W'(common_root(c.na, c.nb));
        n_lca++;
        answer_q.push_back(r);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < REPORT_CAP)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, n_checked, got, want);
    n_errors++;
  endtask

  task automatic push_cmd(input logic [1:0] op, input int na, input int nb,
                          input int par, input int dep, input int k);
    node_cmd_t c;
    c.op = op;
    c.na = NODE_W'(na);
    c.nb = NODE_W'(nb);
    c.par = NODE_W'(par);
    c.dep = DEPTH_W'(dep);
    c.k = STEPS_W'(k);
    command_q.push_back(c);
  endtask

  task automatic push_load(input int v, input int p, input int d);
    push_cmd(blca_pkg::OP_LOAD, v, $urandom_range(0, FIELD_MAX), p, d,
             $urandom_range(0, FIELD_MAX));
    gen_par[v] = p;
    gen_dep[v] = d & FIELD_MAX;
  endtask

  task automatic push_build();
    push_cmd(blca_pkg::OP_BUILD, $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX),
             $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX),
             $urandom_range(0, FIELD_MAX));
  endtask

  task automatic push_kth(input int a, input int k);
    push_cmd(blca_pkg::OP_KTH, a, $urandom_range(0, FIELD_MAX),
             $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX), k);
  endtask

  task automatic push_lca(input int a, input int b);
    push_cmd(blca_pkg::OP_LCA, a, b, $urandom_range(0, FIELD_MAX),
             $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX));
  endtask

  function automatic int shadow_up(input int v, input int hops);
    int cur;
    cur = v;
    for (int i = 0; i < hops; i++) cur = gen_par[cur];
    return cur;
  endfunction

  task automatic load_tree(input tree_shape_t shape);
    int p, d;
    for (int v = 0; v < NODE_COUNT; v++) begin
      if (v == 0) begin
        p = $urandom_range(0, FIELD_MAX);
        d = 0;
      end else begin
        case (shape)
          SHAPE_CHAIN: p = v - 1;
          SHAPE_BUSHY: p = $urandom_range(0, v - 1);
          default:     p = ($urandom_range(0, 99) < 70) ? v - 1 : $urandom_range(0, v - 1);
        endcase
        d = (p == 0) ? 0 : gen_dep[p] + 1;
      end
      push_load(v, p, d);
    end
  endtask

  task automatic random_edit();
    int v, p, d;
    if ($urandom_range(0, 99) < 80) begin
      v = $urandom_range(1, NODE_COUNT - 1);
      p = $urandom_range(0, v - 1);
      d = (p == 0) ? 0 : gen_dep[p] + 1;
    end else begin
      // parent and depth that need not agree with the rest of the tree
      v = $urandom_range(0, NODE_COUNT - 1);
      p = $urandom_range(0, FIELD_MAX);
      d = $urandom_range(0, FIELD_MAX);
    end
    push_load(v, p, d);
  endtask

  task automatic random_query();
    int a, b, k, pick, t;
    a = $urandom_range(0, NODE_COUNT - 1);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      if (pick < 60) k = $urandom_range(0, gen_dep[a] + 1);
      else if (pick < 75) k = gen_dep[a];
      else k = $urandom_range(0, FIELD_MAX);
      if (k > FIELD_MAX) k = FIELD_MAX;
      push_kth(a, k);
    end else begin
      if (pick < 35) begin
        b = $urandom_range(0, NODE_COUNT - 1);
      end else if (pick < 65) begin
        b = shadow_up(a, $urandom_range(0, 30));
      end else if (pick < 85) begin
        b = (a + $urandom_range(1, 20)) % NODE_COUNT;
        a = shadow_up(a, $urandom_range(0, 8));
        b = shadow_up(b, $urandom_range(0, 8));
      end else begin
        b = ($urandom_range(0, 1) == 0) ? a : 0;
      end
      if ($urandom_range(0, 1) == 0) begin
        t = a;
        a = b;
        b = t;
      end
      push_lca(a, b);
    end
  endtask

  // driver: one command in flight on the inputs, start held until transfer
  always @(posedge clk) begin
    logic present;
    node_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      present = start;
      if (start && !busy) begin
        predict_command(shown_cmd);
        n_sent++;
        present = 1'b0;
      end
      if (!present && command_q.size() != 0 &&
          !((n_sent < STEADY_FROM || n_sent >= STEADY_TO) &&
            $urandom_range(0, 99) < IDLE_PCT)) begin
        nxt = command_q.pop_front();
        shown_cmd = nxt;
        operation <= nxt.op;
        node_a <= nxt.na;
        node_b <= nxt.nb;
        parent_in <= nxt.par;
        depth_in <= nxt.dep;
        steps <= nxt.k;
        present = 1'b1;
      end
      start <= present;
    end
  end

  // monitor
  always @(posedge clk) begin
    lca_answer_t want;
    if (!rst && strobe) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result", answer_node, 0);
      end else begin
        want = answer_q.pop_front();
        n_checked++;
        if (answer_node !== want.node) report_mismatch("answer_node", answer_node, want.node);
        if (build_done !== want.done) report_mismatch("build_done", build_done, want.done);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, answer_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int top;
    top = NODE_COUNT - 1;

    // queries with no table yet answer 0
    push_kth(top, FIELD_MAX);
    push_lca(top, 0);
    push_kth(0, 0);

    // every row is loaded once before the first build reads it
    load_tree(SHAPE_MIXED);
    push_build();

    push_kth(top, 0);
    push_kth(top, gen_dep[top]);
    push_kth(top, FIELD_MAX);
    push_kth(0, 0);
    push_kth(0, FIELD_MAX);
    push_kth(1, 1);
    push_lca(top, top);
    push_lca(top, 0);
    push_lca(0, top);
    push_lca(top, top - 1);
    push_lca(1, top);
    push_lca(top, gen_par[top]);
    push_lca(NODE_COUNT / 2, top);

    // a load clears the built flag until the next build
    push_load(top, 1, gen_dep[1] + 1);
    push_kth(top, 1);
    push_lca(top, 1);
    push_build();
    push_kth(top, 1);
    push_lca(top, 1);

    // depths that disagree with the parents, sentinel included
    push_load(700, top, FIELD_MAX);
    push_load(0, top, 5);
    push_build();
    push_lca(700, 3);
    push_kth(700, FIELD_MAX);
    push_lca(0, 700);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 2 || ph == 4) repeat (EDIT_BURST) random_edit();
      else repeat ($urandom_range(1, 8)) random_edit();
      if (ph % 2 == 1) repeat (2) random_query();
      push_build();
      repeat (QUERIES_PER_PHASE) random_query();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (command_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d table builds, %0d kth ancestor and %0d common ancestor queries",
             n_loads, n_builds, n_kth, n_lca);
    $display("%0d results checked, %0d mismatches, %0d cycles", n_checked, n_errors, cycles);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
